FILE: hdl/pcrc16_pkg.sv
// Package for the CRC-16 check/append block: transaction types, command codes, CRC tables.
`default_nettype none

package pcrc16_pkg;

   localparam int unsigned CrcWidth   = 16;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CountWidth = 2;
   localparam int unsigned AddrWidth  = 3;
   localparam int unsigned DataWidth  = 32;

   localparam logic [CountWidth-1:0] MismatchMax = 2'd2;

   // Register index, taken from paddr[2]
   localparam logic RegAppendMode = 1'b0;

   typedef enum logic [1:0] {
      CMD_PAYLOAD  = 2'd0,
      CMD_CHECK_LO = 2'd1,
      CMD_CHECK_HI = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]           command;
      logic [ByteWidth-1:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [ByteWidth-1:0]  out_byte;
      logic [CrcWidth-1:0]   crc_value;
      logic [CountWidth-1:0] mismatch_count;
      logic                  packet_done;
   } rsp_type;

   typedef logic [CrcWidth-1:0] nib_tab_type [16];

   localparam nib_tab_type LoNibTab = '{
      16'o0,      16'o140301, 16'o140601, 16'o500,
      16'o141401, 16'o1700,   16'o1200,   16'o141101,
      16'o143001, 16'o3300,   16'o3600,   16'o143501,
      16'o2400,   16'o142701, 16'o142201, 16'o2100
   };

   localparam nib_tab_type HiNibTab = '{
      16'o0,      16'o146001, 16'o154001, 16'o12000,
      16'o170001, 16'o36000,  16'o24000,  16'o162001,
      16'o120001, 16'o66000,  16'o74000,  16'o132001,
      16'o50000,  16'o116001, 16'o104001, 16'o42000
   };

   // Reflected CRC-16 (0xA001) byte update, two nibble lookups
   function automatic logic [CrcWidth-1:0] crc_update(input logic [CrcWidth-1:0] crc,
                                                      input logic [ByteWidth-1:0] byte_in);
      logic [ByteWidth-1:0] t;
      begin
         t = crc[ByteWidth-1:0] ^ byte_in;
         crc_update = LoNibTab[t[3:0]] ^ HiNibTab[t[7:4]]
                      ^ {{ByteWidth{1'b0}}, crc[CrcWidth-1:ByteWidth]};
      end
   endfunction

endpackage

`default_nettype wire

FILE: hdl/packet_crc16_check_append_top.sv
// Top level: CRC-16 packet checker/appender with valid/ready channels and APB-style CSR.
//
// Usage:
//  - req channel: one transaction per byte; command selects payload byte,
//    low check byte, high check byte or none. Accepted when req_valid && req_ready.
//  - rsp channel: one result per request, in order: the byte passed on (or the
//    computed CRC byte for check bytes when append_mode is set), the running
//    CRC, the mismatch count and packet_done on the high check byte.
//  - CSR: register 0 (byte address 0), bit 0 = append_mode. Write only while idle.
//  - Path: an accepted request sits in the input register, then moves to the
//    result register and is on rsp from then on, until the rsp handshake.
//    Throughput is one byte per cycle while rsp_ready is high;
//    the limit is the CRC byte update in the state loop.
//  - Stall: when rsp_ready is low the result register holds; the input register
//    still takes one more transaction, then req_ready drops until rsp moves.
//  - Reset: synchronous, active high; clears CRC, mismatch count, append_mode
//    and both valid flags. After the high check byte CRC and count clear.
`default_nettype none

module packet_crc16_check_append_top
   import pcrc16_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [AddrWidth-1:0] paddr,
   input  wire logic [DataWidth-1:0] pwdata,
   output logic [DataWidth-1:0]      prdata,
   output logic                      pready
);

   logic                  in_valid_ff, in_valid_in;
   req_type               in_ff, in_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;
   logic [CrcWidth-1:0]   crc_ff, crc_in;
   logic [CountWidth-1:0] mism_ff, mism_in;
   logic                  append_ff, append_in;

   logic                  adv_out;
   logic                  csr_wr;
   logic                  byte_miss;
   logic [ByteWidth-1:0]  chk_byte;
   logic [CountWidth-1:0] cnt_next;
   cmd_type               cmd;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign prdata  = (paddr[2] == RegAppendMode) ? {{(DataWidth-1){1'b0}}, append_ff}
                                                 : '0;

   assign adv_out   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || adv_out;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign cmd       = cmd_type'(in_ff.command);
   assign chk_byte  = (cmd == CMD_CHECK_HI) ? crc_ff[CrcWidth-1:ByteWidth]
                                            : crc_ff[ByteWidth-1:0];
   assign byte_miss = chk_byte != in_ff.data_byte;
   assign cnt_next  = (byte_miss && mism_ff < MismatchMax) ? mism_ff + 2'd1 : mism_ff;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_in        = in_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      crc_in       = crc_ff;
      mism_in      = mism_ff;
      append_in    = append_ff;

      if (csr_wr && paddr[2] == RegAppendMode) begin
         append_in = pwdata[0];
      end

      if (req_ready) begin
         in_valid_in = req_valid;
         in_in       = req_data;
      end

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (adv_out) begin
         out_valid_in          = 1'b1;
         out_in.out_byte       = in_ff.data_byte;
         out_in.crc_value      = crc_ff;
         out_in.mismatch_count = mism_ff;
         out_in.packet_done    = 1'b0;
         unique case (cmd)
            CMD_PAYLOAD: begin
               crc_in           = crc_update(crc_ff, in_ff.data_byte);
               out_in.crc_value = crc_in;
            end
            CMD_CHECK_LO: begin
               mism_in               = cnt_next;
               out_in.mismatch_count = cnt_next;
               if (append_ff) out_in.out_byte = chk_byte;
            end
            CMD_CHECK_HI: begin
               out_in.mismatch_count = cnt_next;
               out_in.packet_done    = 1'b1;
               if (append_ff) out_in.out_byte = chk_byte;
               crc_in  = '0;
               mism_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         crc_ff       <= '0;
         mism_ff      <= '0;
         append_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         crc_ff       <= crc_in;
         mism_ff      <= mism_in;
         append_ff    <= append_in;
      end
   end

   // mismatch count saturates at two
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ff.mismatch_count != 2'd3)
      else $error("mismatch count out of range");

   // high check byte leaves a clean state for the next packet
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (adv_out && cmd == CMD_CHECK_HI) |=> (crc_ff == '0 && mism_ff == '0))
      else $error("state not cleared after packet end");

   // an empty result register never blocks the input side
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_ready)
      else $error("input stalled with empty result register");

   // a result held under stall does not change
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> (out_valid_ff && out_ff == $past(out_ff)))
      else $error("result changed while stalled");

endmodule

`default_nettype wire
